// ===== hdl/itoa_pkg.sv =====
// Package for the integer to decimal ASCII converter.
// Holds character codes, widths and the conversion unit control type.
// No dependencies.
`timescale 1ns / 1ps

package itoa_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 32;
   localparam int CHAR_W              = 8;
   localparam int BCD_W               = 4;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

   // Control word from the sequencer to the shift/add-3 unit
   typedef struct packed {
      logic load;   // take a new magnitude, clear the digits
      logic shift;  // one correction and shift step
   } dab_ctrl_type;

endpackage

// ===== hdl/itoa_if.sv =====
// Valid/ready channel interfaces for the converter.
// Request carries the signed number, response carries one character.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

interface itoa_req_if import itoa_pkg::*; #(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface itoa_rsp_if import itoa_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] text_char;
   logic              last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ===== hdl/itoa_dabble.sv =====
// Shift and add-3 binary to BCD unit, one magnitude bit per step.
// Driven by the sequencer in int_to_decimal_ascii. Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_dabble import itoa_pkg::*; #(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
   parameter int NUM_DIGITS  = 10
) (
   input  logic                          clock,
   input  dab_ctrl_type                  ctrl,
   input  logic [VALUE_WIDTH-1:0]        mag,
   output logic [NUM_DIGITS*BCD_W-1:0]   bcd
);

   logic [VALUE_WIDTH-1:0]        bin_ff, bin_in;
   logic [NUM_DIGITS*BCD_W-1:0]   bcd_ff, bcd_in;
   logic [NUM_DIGITS*BCD_W-1:0]   adj;

   // Correct every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*BCD_W +: BCD_W] >= 4'd5) begin
            adj[i*BCD_W +: BCD_W] = bcd_ff[i*BCD_W +: BCD_W] + 4'd3;
         end else begin
            adj[i*BCD_W +: BCD_W] = bcd_ff[i*BCD_W +: BCD_W];
         end
      end
   end

   // Load a new magnitude or shift the top binary bit into the digits
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = mag;
         bcd_in = '0;
      end else if (ctrl.shift) begin
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {adj[NUM_DIGITS*BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd = bcd_ff;

endmodule

// ===== hdl/int_to_decimal_ascii.sv =====
// Top level of the integer to decimal ASCII converter.
// Holds the sequencer and the output register; uses itoa_dabble, itoa_if and itoa_pkg.
`timescale 1ns / 1ps

// Converts one signed VALUE_WIDTH-bit number per request word into its decimal text,
// one ASCII character per response word, most significant first, with a leading '-'
// for negative values and last_char set on the final digit. Zero gives "0"; the most
// negative value prints its full magnitude. The conversion runs through a shift and
// add-3 BCD unit that takes one magnitude bit per cycle. An item goes through accept,
// conversion and digit scan, then its characters are emitted while the response side
// is ready. Requests are refused until the last character of the current number has
// been loaded into the output register.

module int_to_decimal_ascii import itoa_pkg::*; #(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   itoa_req_if.sink  req_if,
   itoa_rsp_if.source rsp_if
);

   localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int POS_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic                          neg_ff, neg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]             char_ff, char_in;
   logic                          last_ff, last_in;

   dab_ctrl_type                  dab_ctrl;
   logic [VALUE_WIDTH-1:0]        mag;
   logic [NUM_DIGITS*BCD_W-1:0]   bcd;
   logic [POS_W-1:0]              top_pos;
   logic [BCD_W-1:0]              cur_digit;
   logic                          req_take;
   logic                          out_free;

   assign req_take = req_if.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Form the unsigned magnitude of the request word
   assign mag = req_if.number[VALUE_WIDTH-1] ? (~req_if.number + 1'b1) : req_if.number;

   itoa_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_dabble (
      .clock (clock),
      .ctrl  (dab_ctrl),
      .mag   (mag),
      .bcd   (bcd)
   );

   // Find the most significant nonzero digit, position zero when all are zero
   always_comb begin
      top_pos = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd[i*BCD_W +: BCD_W] != '0) begin
            top_pos = POS_W'(i);
         end
      end
   end

   assign cur_digit = bcd[pos_ff*BCD_W +: BCD_W];

   // Sequencer: load, convert, scan, then emit sign and digits
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      dab_ctrl     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               dab_ctrl.load = 1'b1;
               neg_in        = req_if.number[VALUE_WIDTH-1];
               cnt_in        = '0;
               state_in      = ST_CONV;
            end
         end
         ST_CONV: begin
            dab_ctrl.shift = 1'b1;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VALUE_WIDTH - 1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pos_in   = top_pos;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  char_in = CH_MINUS;
                  last_in = 1'b0;
                  neg_in  = 1'b0;
               end else begin
                  char_in = CH_ZERO | CHAR_W'(cur_digit);
                  last_in = (pos_ff == '0);
                  pos_in  = pos_ff - 1'b1;
                  if (pos_ff == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance payload and counters
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      pos_ff  <= pos_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.text_char = char_ff;
   assign rsp_if.last_char = last_ff;

endmodule

// ===== sim/tb_int_to_decimal_ascii.sv =====
// Testbench for int_to_decimal_ascii: drives signed numbers, checks every character word.
// Depends on itoa_pkg, itoa_if and the int_to_decimal_ascii top level.
`timescale 1ns / 1ps

import itoa_pkg::*;

localparam int TB_VALUE_W = DEFAULT_VALUE_WIDTH;
localparam int RADIX      = 10;

typedef struct {
   logic [CHAR_W-1:0] text_char;
   logic              last_char;
} text_word_type;

// Holds the expected text of accepted numbers and checks each response word against it
class decimal_text_board;
   text_word_type text_q[$];
   int unsigned   errors;

   function new();
      errors = 0;
   endfunction

   // Work out the decimal text of one accepted number
   function void note_number(input logic [TB_VALUE_W-1:0] number);
      logic [TB_VALUE_W-1:0] magnitude;
      logic [CHAR_W-1:0]     digit_q[$];
      text_word_type         w;
      logic                  negative;
      negative  = number[TB_VALUE_W-1];
      magnitude = negative ? (~number + 1'b1) : number;
      // peel digits least significant first, store most significant first
      do begin
         digit_q.push_front(CH_ZERO + CHAR_W'(magnitude % RADIX));
         magnitude = magnitude / RADIX;
      end while (magnitude != 0);
      if (negative) begin
         w.text_char = CH_MINUS;
         w.last_char = 1'b0;
         text_q.push_back(w);
      end
      foreach (digit_q[i]) begin
         w.text_char = digit_q[i];
         w.last_char = (i == digit_q.size() - 1);
         text_q.push_back(w);
      end
   endfunction

   // Compare one response word with the oldest expected character
   function void check_char(input logic [CHAR_W-1:0] text_char, input logic last_char);
      text_word_type w;
      if (text_q.size() == 0) begin
         $error("text_char: unexpected word, expected none, got %h (last_char %b)",
                text_char, last_char);
         errors++;
         return;
      end
      w = text_q.pop_front();
      if (text_char !== w.text_char) begin
         $error("text_char mismatch: expected %h, got %h", w.text_char, text_char);
         errors++;
      end
      if (last_char !== w.last_char) begin
         $error("last_char mismatch: expected %b, got %b", w.last_char, last_char);
         errors++;
      end
   endfunction

   function int pending();
      return text_q.size();
   endfunction
endclass

module tb_int_to_decimal_ascii;

   logic clock;
   logic reset;
   int   src_idle_pct;
   int   snk_stall_pct;

   decimal_text_board board;

   itoa_req_if #(.VALUE_WIDTH(TB_VALUE_W)) req_if ();
   itoa_rsp_if                             rsp_if ();

   int_to_decimal_ascii #(.VALUE_WIDTH(TB_VALUE_W)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hold inputs at known values from time zero
   initial begin
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.number = '0;
      rsp_if.ready  = 1'b0;
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      board         = new();
   end

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
   end

   // Note accepted numbers and check accepted characters
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) board.note_number(req_if.number);
         if (rsp_if.valid && rsp_if.ready) board.check_char(rsp_if.text_char, rsp_if.last_char);
      end
   end

   // Offer one number; return at the falling edge after it was taken, valid still high
   task automatic send_number(input logic [TB_VALUE_W-1:0] number);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.number <= number;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Draw a number: mostly a random digit count with random sign, sometimes raw bits
   function automatic logic [TB_VALUE_W-1:0] draw_number();
      longint lo;
      longint hi;
      int     ndig;
      logic [TB_VALUE_W-1:0] value;
      if ($urandom_range(0, 3) == 0) return $urandom;
      ndig = $urandom_range(1, 10);
      lo = 1;
      for (int i = 1; i < ndig; i++) lo = lo * RADIX;
      hi = lo * RADIX - 1;
      if (ndig == 1) lo = 0;
      if (hi > 64'd2147483648) hi = 64'd2147483648;
      value = TB_VALUE_W'(lo + ($urandom % (hi - lo + 1)));
      if ($urandom_range(0, 1)) value = ~value + 1'b1;
      return value;
   endfunction

   // Fixed upper bound on the run
   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [TB_VALUE_W-1:0] directed_q[$];
      int                    drain;
      directed_q = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                     32'sd100, -32'sd909, 32'sd12345, 32'sd999999999, 32'sd1000000000,
                     -32'sd1000000000, 32'sd2147483647, 32'h8000_0000, -32'sd2147483647,
                     32'h5555_5555, 32'hAAAA_AAAA, -32'sd7, 32'sd4294};

      // Hold reset, then release it at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Extremes and special cases, no idling
      foreach (directed_q[i]) send_number(directed_q[i]);

      // Random words over the idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 83; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 83; end
            default: begin src_idle_pct = 28; snk_stall_pct = 28; end
         endcase
         repeat (50) send_number(draw_number());
      end
      req_if.valid <= 1'b0;

      // Drain outstanding characters, then watch for stray words
      while (board.pending() != 0) @(posedge clock);
      drain = 2 * (TB_VALUE_W + 2 + 11);
      repeat (drain) @(posedge clock);

      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
